FILE: rtl/carm_pkg.sv
// Shared definitions for the relocation map: operation codes, word widths
// and the table write control bundle. No dependencies.
package carm_pkg;

	// Width of the address fields carried on the channels
	localparam int FIELD_W = 48;
	localparam int OP_W    = 2;

	localparam logic [OP_W-1:0] OP_RECORD    = 2'd0;
	localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR     = 2'd2;

	// Piece table write control
	typedef struct packed {
		logic en;     // write this cycle
		logic whole;  // 1: start, end and offset; 0: end only
	} carm_wr_t;

endpackage

FILE: rtl/carm_in_if.sv
// Request channel of the relocation map: valid/ready plus one request word.
// Depends on carm_pkg.
interface carm_in_if;
	logic                           valid;
	logic                           ready;
	logic [carm_pkg::OP_W-1:0]      operation;
	logic [carm_pkg::FIELD_W-1:0]   src_addr;
	logic [carm_pkg::FIELD_W-1:0]   dst_addr;

	modport source (output valid, output operation, output src_addr, output dst_addr,
		input ready);
	modport sink (input valid, input operation, input src_addr, input dst_addr,
		output ready);
endinterface

FILE: rtl/carm_out_if.sv
// Response channel of the relocation map: valid/ready plus one response word.
// Depends on carm_pkg.
interface carm_out_if;
	logic                           valid;
	logic                           ready;
	logic [carm_pkg::FIELD_W-1:0]   result_addr;
	logic                           mapped;
	logic                           status;

	modport source (output valid, output result_addr, output mapped, output status,
		input ready);
	modport sink (input valid, input result_addr, input mapped, input status,
		output ready);
endinterface

FILE: rtl/run_compressed_address_relocation_map.sv
// Run-compressed address relocation map, top level with its sequencer.
// Depends on carm_pkg, carm_in_if, carm_out_if, carm_alu and carm_table.
//
// Takes one request word at a time (req.ready is high only while idle) and
// returns exactly one response word for each. A record passes through
// S_REC_OFF and S_REC_STEP, a clear or an unused code goes straight to
// S_FIN, and a translate passes through S_TR_SCAN, S_TR_END and S_TR_ADD:
// the scan reads the stored pieces (at most MAX_PIECES) one entry per cycle
// through its single registered read port, waits for the last entry's data
// and for the pipe to empty, and checks each entry with the one shared
// add/subtract unit, which also forms offsets, run steps and the final sum.
// A finished response waits in the output register; the next request is
// accepted while it waits, and the sequencer stalls only at its last step if
// the previous response has still not been taken. The newest piece's end and
// offset are mirrored in registers so a record never reads the table.
module run_compressed_address_relocation_map #(
	parameter int MAX_PIECES = 64,
	parameter int ADDR_BITS  = 48
) (
	input  logic           clk,
	input  logic           arst_n,
	carm_in_if.sink        req,
	carm_out_if.source     rsp
);
	localparam int AW = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
	localparam int CW = $clog2(MAX_PIECES + 1);
	localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PIECES);

	// sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_REC_OFF  = 3'd1;
	localparam logic [2:0] S_REC_STEP = 3'd2;
	localparam logic [2:0] S_TR_SCAN  = 3'd3;
	localparam logic [2:0] S_TR_END   = 3'd4;
	localparam logic [2:0] S_TR_ADD   = 3'd5;
	localparam logic [2:0] S_FIN      = 3'd6;

	// control
	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic          rdv_q;     // table read data valid this cycle
	logic          found_q;
	logic          out_valid_q;
	logic [ADDR_BITS-1:0] stride_q;

	// payload
	logic [ADDR_BITS-1:0] src_q, dst_q, off_q;
	logic [ADDR_BITS-1:0] last_end_q, last_off_q;
	logic [ADDR_BITS-1:0] best_start_q, best_end_q, best_off_q;
	logic [ADDR_BITS-1:0] res_q;
	logic                 hit_q, stat_q;
	logic [carm_pkg::FIELD_W-1:0] out_addr_q;
	logic                 out_mapped_q, out_status_q;

	logic accept, out_free;
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// shared add/subtract unit
	logic                 alu_sub, alu_ge;
	logic [ADDR_BITS-1:0] alu_a, alu_b, alu_res;

	carm_alu #(.W(ADDR_BITS)) u_alu (
		.sub (alu_sub),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res),
		.ge  (alu_ge)
	);

	logic [ADDR_BITS-1:0] rd_start, rd_end, rd_off;

	always_comb begin
		alu_sub = 1'b1;
		alu_a   = src_q;
		alu_b   = dst_q;
		case (state_q)
			S_REC_OFF: begin   // offset = new - old
				alu_a = dst_q;
				alu_b = src_q;
			end
			S_REC_STEP: begin  // step from newest piece end
				alu_a = src_q;
				alu_b = last_end_q;
			end
			S_TR_SCAN: begin   // start <= address
				alu_a = src_q;
				alu_b = rd_start;
			end
			S_TR_END: begin    // address <= chosen piece end
				alu_a = best_end_q;
				alu_b = src_q;
			end
			S_TR_ADD: begin    // address + offset
				alu_sub = 1'b0;
				alu_a   = src_q;
				alu_b   = best_off_q;
			end
			default: begin
				alu_sub = 1'b1;
			end
		endcase
	end

	// record decision
	logic extend;
	assign extend = (count_q != '0) && (off_q == last_off_q) && alu_ge &&
		(alu_res != '0) && ((stride_q == '0) || (alu_res == stride_q));

	logic [CW-1:0] last_idx;
	assign last_idx = count_q - CW'(1);

	carm_pkg::carm_wr_t wr;
	logic [AW-1:0]      wr_addr;
	assign wr.en    = (state_q == S_REC_STEP) && (extend || (count_q != COUNT_MAX));
	assign wr.whole = !extend;
	assign wr_addr  = extend ? last_idx[AW-1:0] : count_q[AW-1:0];

	logic issue;
	assign issue = (state_q == S_TR_SCAN) && (idx_q != count_q);

	carm_table #(.DEPTH(MAX_PIECES), .AW(AW), .W(ADDR_BITS)) u_table (
		.clk      (clk),
		.wr       (wr),
		.wr_addr  (wr_addr),
		.wr_src   (src_q),
		.wr_off   (off_q),
		.rd_addr  (idx_q[AW-1:0]),
		.rd_start (rd_start),
		.rd_end   (rd_end),
		.rd_off   (rd_off)
	);

	// later entries win ties on equal start
	logic take;
	assign take = (state_q == S_TR_SCAN) && rdv_q && alu_ge &&
		(!found_q || (rd_start >= best_start_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rdv_q       <= 1'b0;
			found_q     <= 1'b0;
			stride_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.operation)
							carm_pkg::OP_RECORD: begin
								state_q <= S_REC_OFF;
							end
							carm_pkg::OP_TRANSLATE: begin
								state_q <= S_TR_SCAN;
								idx_q   <= '0;
								rdv_q   <= 1'b0;
								found_q <= 1'b0;
							end
							carm_pkg::OP_CLEAR: begin
								count_q  <= '0;
								stride_q <= '0;
								state_q  <= S_FIN;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_REC_OFF: begin
					state_q <= S_REC_STEP;
				end
				S_REC_STEP: begin
					if (extend) begin
						stride_q <= alu_res;
					end else if (count_q != COUNT_MAX) begin
						count_q  <= count_q + CW'(1);
						stride_q <= '0;
					end
					state_q <= S_FIN;
				end
				S_TR_SCAN: begin
					rdv_q <= issue;
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (take) begin
						found_q <= 1'b1;
					end
					if (!issue && !rdv_q) begin
						state_q <= S_TR_END;
					end
				end
				S_TR_END: begin
					state_q <= S_TR_ADD;
				end
				S_TR_ADD: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// response valid: set when a word is loaded, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [63:0] res_wide;
	assign res_wide = 64'(res_q);

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					src_q  <= ADDR_BITS'(req.src_addr);
					dst_q  <= ADDR_BITS'(req.dst_addr);
					res_q  <= '0;
					hit_q  <= 1'b0;
					stat_q <= 1'b0;
				end
			end
			S_REC_OFF: begin
				off_q <= alu_res;
			end
			S_REC_STEP: begin
				if (extend) begin
					last_end_q <= src_q;
				end else if (count_q != COUNT_MAX) begin
					last_end_q <= src_q;
					last_off_q <= off_q;
				end else begin
					stat_q <= 1'b1;  // table full, row dropped
				end
			end
			S_TR_SCAN: begin
				if (take) begin
					best_start_q <= rd_start;
					best_end_q   <= rd_end;
					best_off_q   <= rd_off;
				end
			end
			S_TR_END: begin
				hit_q <= found_q && alu_ge;
			end
			S_TR_ADD: begin
				res_q <= hit_q ? alu_res : src_q;
			end
			S_FIN: begin
				if (out_free) begin
					out_addr_q   <= res_wide[carm_pkg::FIELD_W-1:0];
					out_mapped_q <= hit_q;
					out_status_q <= stat_q;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_addr = out_addr_q;
	assign rsp.mapped      = out_mapped_q;
	assign rsp.status      = out_status_q;

	// table never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_MAX)
		else $error("piece count above table depth");

	// clear empties the table on the next edge
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.operation == carm_pkg::OP_CLEAR) |=> count_q == '0)
		else $error("clear did not empty the table");

	// scan only reads stored pieces
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> idx_q < count_q)
		else $error("scan read beyond stored pieces");

	// a drop happens only with a full table
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REC_STEP) && !extend && (count_q != COUNT_MAX) |=> !stat_q)
		else $error("row dropped with room in the table");

	// a response is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready && (state_q == S_FIN) |=> state_q == S_FIN)
		else $error("pending response overwritten");
endmodule

FILE: rtl/carm_alu.sv
// Shared add/subtract unit of the relocation map; a - b or a + b with the
// unsigned a >= b flag on subtract. No dependencies.
module carm_alu #(
	parameter int W = 48
) (
	input  logic         sub,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] res,
	output logic         ge
);
	logic [W:0] sum;

	// carry out of a + ~b + 1 is set exactly when a >= b
	assign sum = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
	assign res = sum[W-1:0];
	assign ge  = sum[W];
endmodule

FILE: rtl/carm_table.sv
// Piece table storage: start, end and offset arrays, one write port and one
// registered read port. Depends on carm_pkg.
module carm_table #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int W     = 48
) (
	input  logic               clk,
	input  carm_pkg::carm_wr_t wr,
	input  logic [AW-1:0]      wr_addr,
	input  logic [W-1:0]       wr_src,
	input  logic [W-1:0]       wr_off,
	input  logic [AW-1:0]      rd_addr,
	output logic [W-1:0]       rd_start,
	output logic [W-1:0]       rd_end,
	output logic [W-1:0]       rd_off
);
	logic [W-1:0] start_mem [DEPTH];
	logic [W-1:0] end_mem   [DEPTH];
	logic [W-1:0] off_mem   [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			end_mem[wr_addr] <= wr_src;
			if (wr.whole) begin
				start_mem[wr_addr] <= wr_src;
				off_mem[wr_addr]   <= wr_off;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_start <= start_mem[rd_addr];
		rd_end   <= end_mem[rd_addr];
		rd_off   <= off_mem[rd_addr];
	end
endmodule

FILE: tb/run_compressed_address_relocation_map_tb.sv
// Testbench for run_compressed_address_relocation_map: random-gap driver, stalling
// response monitor and an in-bench piece table predictor checked word by word.
// Depends on carm_pkg, carm_in_if, carm_out_if and the block itself.
module run_compressed_address_relocation_map_tb;

	localparam int TABLE_DEPTH  = 64;
	localparam int RANDOM_WORDS = 550;
	// the quiet tail covers the longest translate, a scan of a full table
	localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
	localparam logic [carm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	typedef logic [carm_pkg::FIELD_W-1:0] addr_t;

	typedef struct {
		logic [carm_pkg::OP_W-1:0] operation;
		addr_t                     src_addr;
		addr_t                     dst_addr;
	} request_t;

	typedef struct {
		addr_t result_addr;
		logic  mapped;
		logic  status;
	} response_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	carm_in_if  req_ch();
	carm_out_if rsp_ch();

	run_compressed_address_relocation_map #(
		.MAX_PIECES(TABLE_DEPTH),
		.ADDR_BITS (carm_pkg::FIELD_W)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predicted piece table: bounds and offset per piece, plus the stride of
	// the newest piece (zero while it still holds a single row).
	addr_t piece_lo    [TABLE_DEPTH];
	addr_t piece_hi    [TABLE_DEPTH];
	addr_t piece_delta [TABLE_DEPTH];
	int    pieces_held = 0;
	addr_t run_step    = '0;

	request_t  request_q[$];       // words waiting for the driver
	response_t expected_rsp_q[$];  // predicted response words, oldest first
	addr_t     recorded_src_q[$];  // recent row addresses, aim for translates
	int        words_queued = 0;
	int        errors = 0;

	// handshake flags sampled at the rising edge, consumed at the falling edge
	bit req_taken  = 1'b0;
	bit rsp_taken  = 1'b0;
	int send_gap   = 0;
	int recv_stall = 0;
	bit send_burst = 1'b0;
	bit recv_burst = 1'b0;

	function automatic addr_t rand48();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[carm_pkg::FIELD_W-1:0];
	endfunction

	// Mostly back to back, sometimes a short pause, rarely a long one.
	function automatic int idle_gap(bit burst);
		int roll;
		roll = $urandom_range(0, 99);
		if (burst || roll < 60) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Translate target: near a recorded row (edges of pieces) or anywhere.
	function automatic addr_t pick_near();
		if (recorded_src_q.size() == 0 || $urandom_range(0, 4) == 0) return rand48();
		return recorded_src_q[$urandom_range(0, recorded_src_q.size() - 1)]
			+ addr_t'($urandom_range(0, 8)) - addr_t'(4);
	endfunction

	task automatic push_word(logic [carm_pkg::OP_W-1:0] op, addr_t src, addr_t dst);
		request_t w;
		w.operation = op;
		w.src_addr  = src;
		w.dst_addr  = dst;
		request_q = {request_q, w};
		words_queued++;
	endtask

	task automatic note_src(addr_t src);
		recorded_src_q = {recorded_src_q, src};
		if (recorded_src_q.size() > 64) void'(recorded_src_q.pop_front());
	endtask

	// Applies one accepted request to the predicted table and returns the
	// response word it must produce.
	function automatic response_t relocate_word(request_t w);
		response_t r;
		addr_t     delta;
		addr_t     step;
		int        last;
		int        best;
		bit        extended;
		bit        found;
		r.result_addr = '0;
		r.mapped      = 1'b0;
		r.status      = 1'b0;
		extended      = 1'b0;
		found         = 1'b0;
		best          = 0;
		case (w.operation)
		carm_pkg::OP_RECORD: begin
			delta = w.dst_addr - w.src_addr;
			if (pieces_held > 0) begin
				last = pieces_held - 1;
				// same offset, strictly above the end, and on the stride
				if (delta == piece_delta[last] && w.src_addr > piece_hi[last]) begin
					step = w.src_addr - piece_hi[last];
					if (run_step == '0 || step == run_step) begin
						run_step       = step;
						piece_hi[last] = w.src_addr;
						extended       = 1'b1;
					end
				end
			end
			if (!extended) begin
				if (pieces_held >= TABLE_DEPTH) begin
					r.status = 1'b1;  // table full: row dropped
				end else begin
					piece_lo[pieces_held]    = w.src_addr;
					piece_hi[pieces_held]    = w.src_addr;
					piece_delta[pieces_held] = delta;
					pieces_held++;
					run_step = '0;
				end
			end
		end
		carm_pkg::OP_TRANSLATE: begin
			r.result_addr = w.src_addr;
			// greatest start at or below the address; newest wins a tie
			for (int i = 0; i < pieces_held; i++) begin
				if (piece_lo[i] <= w.src_addr && (!found || piece_lo[i] >= piece_lo[best])) begin
					best  = i;
					found = 1'b1;
				end
			end
			if (found && w.src_addr <= piece_hi[best]) begin
				r.result_addr = w.src_addr + piece_delta[best];
				r.mapped      = 1'b1;
			end
		end
		carm_pkg::OP_CLEAR: begin
			pieces_held = 0;
			run_step    = '0;
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	// Driver: a new word goes out only once the previous one was taken
	// (or nothing was on the bus), after its random gap has run out.
	always @(negedge clk) begin
		request_t w;
		if (arst_n && (!req_ch.valid || req_taken)) begin
			if (send_gap > 0) begin
				req_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (request_q.size() != 0) begin
				w = request_q.pop_front();
				req_ch.valid     <= 1'b1;
				req_ch.operation <= w.operation;
				req_ch.src_addr  <= w.src_addr;
				req_ch.dst_addr  <= w.dst_addr;
				send_gap <= idle_gap(send_burst);
				if ($urandom_range(0, 40) == 0) send_burst <= !send_burst;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Response side back-pressure: a stall is drawn after each taken word and
	// now and then out of the blue, so it also lands while the block is busy.
	always @(negedge clk) begin
		if (arst_n) begin
			if (recv_stall > 0) begin
				rsp_ch.ready <= 1'b0;
				recv_stall <= recv_stall - 1;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (rsp_taken || $urandom_range(0, 15) == 0) begin
					recv_stall <= idle_gap(recv_burst);
					if ($urandom_range(0, 40) == 0) recv_burst <= !recv_burst;
				end
			end
		end
	end

	// Monitor: checks each taken response against the oldest prediction, then
	// predicts for a request taken at the same edge.
	always @(posedge clk) begin
		response_t want;
		request_t  seen;
		req_taken <= req_ch.valid && req_ch.ready;
		rsp_taken <= rsp_ch.valid && rsp_ch.ready;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsp_q.size() == 0) begin
					$error("unexpected response word: result_addr %h mapped %b status %b",
						rsp_ch.result_addr, rsp_ch.mapped, rsp_ch.status);
					errors++;
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp_ch.result_addr !== want.result_addr) begin
						$error("result_addr: expected %h, got %h", want.result_addr,
							rsp_ch.result_addr);
						errors++;
					end
					if (rsp_ch.mapped !== want.mapped) begin
						$error("mapped: expected %b, got %b", want.mapped, rsp_ch.mapped);
						errors++;
					end
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %b, got %b", want.status, rsp_ch.status);
						errors++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				seen.operation = req_ch.operation;
				seen.src_addr  = req_ch.src_addr;
				seen.dst_addr  = req_ch.dst_addr;
				expected_rsp_q = {expected_rsp_q, relocate_word(seen)};
			end
		end
	end

	initial begin
		addr_t base;
		addr_t src;
		addr_t delta;
		addr_t step;
		addr_t last_src;
		addr_t last_delta;
		int    random_from;

		req_ch.valid     = 1'b0;
		req_ch.operation = carm_pkg::OP_CLEAR;
		req_ch.src_addr  = '0;
		req_ch.dst_addr  = '0;
		rsp_ch.ready     = 1'b0;

		// Directed: empty table, unused code, run building and breaking,
		// duplicate starts, wrap at both address extremes, clear.
		push_word(carm_pkg::OP_TRANSLATE, 48'h0, 48'hFFFF_FFFF_FFFF);
		push_word(carm_pkg::OP_TRANSLATE, 48'hFFFF_FFFF_FFFF, 48'h0);
		push_word(OP_UNUSED, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		push_word(carm_pkg::OP_RECORD, 48'h1000, 48'h5000);
		push_word(carm_pkg::OP_RECORD, 48'h1010, 48'h5010);  // stride 16 set
		push_word(carm_pkg::OP_RECORD, 48'h1020, 48'h5020);  // on stride, extends
		push_word(carm_pkg::OP_RECORD, 48'h1028, 48'h5028);  // off stride, new piece
		push_word(carm_pkg::OP_RECORD, 48'h1030, 48'h5030);  // single-row piece takes step 8
		push_word(carm_pkg::OP_RECORD, 48'h1028, 48'h9028);  // same start as previous piece
		push_word(carm_pkg::OP_TRANSLATE, 48'h1028, 48'h0);  // newest of equal starts wins
		push_word(carm_pkg::OP_TRANSLATE, 48'h1030, 48'h0);  // past its end: unmapped
		push_word(carm_pkg::OP_TRANSLATE, 48'h1018, 48'h0);
		push_word(carm_pkg::OP_TRANSLATE, 48'h0FFF, 48'h0);  // below every piece
		push_word(carm_pkg::OP_RECORD, 48'hFFFF_FFFF_FFFF, 48'h0);
		push_word(carm_pkg::OP_TRANSLATE, 48'hFFFF_FFFF_FFFF, 48'h0);  // sum wraps to zero
		push_word(carm_pkg::OP_RECORD, 48'h0, 48'hFFFF_FFFF_FFFF);
		push_word(carm_pkg::OP_TRANSLATE, 48'h0, 48'h0);
		push_word(carm_pkg::OP_RECORD, 48'h2000, 48'h0100);  // negative offset
		push_word(carm_pkg::OP_TRANSLATE, 48'h2000, 48'hFFFF_FFFF_FFFF);
		push_word(carm_pkg::OP_CLEAR, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		push_word(carm_pkg::OP_TRANSLATE, 48'h1000, 48'h0);
		push_word(OP_UNUSED, 48'h0, 48'h0);

		random_from = words_queued;
		while (words_queued - random_from < RANDOM_WORDS) begin
			if ($urandom_range(0, 11) == 0) begin
				// Overfill: a full table drops new pieces but still lets the
				// newest piece grow.
				push_word(carm_pkg::OP_CLEAR, rand48(), rand48());
				base = rand48();
				for (int i = 0; i < TABLE_DEPTH + 4; i++) begin
					src   = base + addr_t'(i) * addr_t'(256);
					delta = rand48();
					push_word(carm_pkg::OP_RECORD, src, src + delta);
					note_src(src);
					if (i == TABLE_DEPTH - 1) begin
						last_src   = src;
						last_delta = delta;
					end
				end
				src = last_src + addr_t'(3);
				push_word(carm_pkg::OP_RECORD, src, src + last_delta);
				push_word(carm_pkg::OP_RECORD, src + addr_t'(3),
					src + addr_t'(3) + last_delta);
				push_word(carm_pkg::OP_RECORD, src + addr_t'(7),
					src + addr_t'(7) + last_delta);
				repeat (8) push_word(carm_pkg::OP_TRANSLATE, pick_near(), rand48());
			end else begin
				// Runs of rows with random offset and stride, some broken,
				// translates mixed in and aimed at the recorded rows.
				if ($urandom_range(0, 3) != 0) push_word(carm_pkg::OP_CLEAR, rand48(), rand48());
				src   = ($urandom_range(0, 1) != 0) ? rand48() : addr_t'($urandom_range(0, 65535));
				delta = rand48();
				repeat ($urandom_range(1, 8)) begin
					if ($urandom_range(0, 3) != 0) begin
						delta = ($urandom_range(0, 2) != 0) ? rand48()
							: addr_t'($urandom_range(0, 4096));
					end
					step = ($urandom_range(0, 4) != 0) ? addr_t'($urandom_range(1, 64)) : rand48();
					repeat ($urandom_range(1, 6)) begin
						push_word(carm_pkg::OP_RECORD, src, src + delta);
						note_src(src);
						if ($urandom_range(0, 7) == 0)
							push_word(carm_pkg::OP_TRANSLATE, pick_near(), rand48());
						if ($urandom_range(0, 9) == 0) src = src + addr_t'(1);  // break the stride
						src = src + step;
					end
					src = ($urandom_range(0, 4) != 0) ? src + addr_t'($urandom_range(0, 512)) : rand48();
					if ($urandom_range(0, 5) == 0) begin
						push_word(($urandom_range(0, 1) != 0) ? OP_UNUSED : carm_pkg::OP_RECORD,
							rand48(), rand48());
					end
				end
				repeat ($urandom_range(2, 8))
					push_word(carm_pkg::OP_TRANSLATE, pick_near(), rand48());
			end
		end

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// drain: everything sent, everything answered, then a quiet tail
		while (request_q.size() != 0 || req_ch.valid || expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

	// hang guard, many times the slowest legal run
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
rtl/carm_pkg.sv
rtl/carm_in_if.sv
rtl/carm_out_if.sv
rtl/carm_alu.sv
rtl/carm_table.sv
rtl/run_compressed_address_relocation_map.sv
tb/run_compressed_address_relocation_map_tb.sv
